@@ rtl/tpcc_pkg.sv @@
`default_nettype none

package tpcc_pkg;

    // ADC sample and DC estimate format
    localparam int SAMPLE_BITS      = 16;
    localparam int DC_FRACTION_BITS = 16;

    // Field widths
    localparam int RAW_W     = 16;               // sample ports
    localparam int OUT_W     = 16;               // current ports and low-pass state
    localparam int NEG_W     = RAW_W + 2;        // offset minus sample
    localparam int GAIN_W    = 16;
    localparam int SHIFT_W   = 5;
    localparam int ALPHA_W   = 31;               // DC weight, Q31
    localparam int ALPHA_FRAC = 31;
    localparam int LP_W      = 15;               // low-pass weights, Q15
    localparam int LP_FRAC   = 15;

    // Internal datapath widths
    localparam int PROD_W    = 34;               // scaled sample v
    localparam int EST_W     = 48;               // DC estimate
    localparam int DIFF_W    = EST_W + 1;        // target minus estimate
    localparam int LO_W      = 25;               // low slice of the difference
    localparam int HI_W      = DIFF_W - LO_W;    // signed high slice
    localparam int LO_P_W    = ALPHA_W + LO_W;
    localparam int HI_P_W    = ALPHA_W + 1 + HI_W;
    localparam int UP_W      = HI_P_W + 1;
    localparam int Q_SHIFT   = ALPHA_FRAC - LO_W;
    localparam int C_W       = PROD_W + 1;       // difference after DC removal
    localparam int M1_W      = LP_W + 1 + C_W;
    localparam int M2_W      = LP_W + 1 + OUT_W;
    localparam int SUM_W     = M1_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_ADC_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHIFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DC_ALPHA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LP_ALPHA     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LP_ONE_MINUS = 3'd5;

    localparam logic [RAW_W-1:0]   RST_ADC_OFFSET   = 16'd2553;
    localparam logic [GAIN_W-1:0]  RST_COUNT_GAIN   = 16'd925;
    localparam logic [SHIFT_W-1:0] RST_GAIN_SHIFT   = 5'd5;
    localparam logic [ALPHA_W-1:0] RST_DC_ALPHA     = 31'd674440;
    localparam logic [LP_W-1:0]    RST_LP_ALPHA     = 15'd8192;
    localparam logic [LP_W-1:0]    RST_LP_ONE_MINUS = 15'd24576;

    localparam logic [RAW_W-1:0] SAMPLE_MASK =
        RAW_W'((longint'(1) <<< SAMPLE_BITS) - longint'(1));

    typedef struct packed {
        logic [RAW_W-1:0]   adc_offset;
        logic [GAIN_W-1:0]  count_gain;
        logic [SHIFT_W-1:0] gain_shift;
        logic [ALPHA_W-1:0] dc_alpha;
        logic [LP_W-1:0]    lp_alpha;
        logic [LP_W-1:0]    lp_one_minus;
    } cfg_t;

    // Top level to lanes
    typedef struct packed {
        logic start;        // input transfer, capture sample
        logic stationary;   // update the DC estimate for this item
        logic take;         // merge stage collects the result
    } lane_ctrl_t;

    // Lane to top level and merge stage
    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

endpackage

`default_nettype wire

@@ rtl/tpcc_lane.sv @@
`default_nettype none

// One phase: offset/gain scaling, DC tracking and removal, Q15 low-pass.
// A small sequencer steps the datapath through its states; a new sample is taken only in idle.
module tpcc_lane (
    input  wire                          clk,
    input  wire                          rst_n,
    input  tpcc_pkg::cfg_t               cfg,
    input  tpcc_pkg::lane_ctrl_t         ctrl,
    input  wire [tpcc_pkg::RAW_W-1:0]    sample,
    output tpcc_pkg::lane_stat_t         stat,
    output logic signed [tpcc_pkg::OUT_W-1:0] result
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_SHIFT = 4'd2;
    localparam logic [3:0] ST_DIFF  = 4'd3;
    localparam logic [3:0] ST_PLO   = 4'd4;
    localparam logic [3:0] ST_PHI   = 4'd5;
    localparam logic [3:0] ST_QUO   = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_RND   = 4'd8;
    localparam logic [3:0] ST_LPM   = 4'd9;
    localparam logic [3:0] ST_LPS   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    localparam int EST_W  = tpcc_pkg::EST_W;
    localparam int DIFF_W = tpcc_pkg::DIFF_W;
    localparam int PROD_W = tpcc_pkg::PROD_W;
    localparam int OUT_W  = tpcc_pkg::OUT_W;
    localparam int F      = tpcc_pkg::DC_FRACTION_BITS;

    // DC filter input range and rounding constants
    localparam logic signed [EST_W-1:0] DC_LIM_HI =
        EST_W'((longint'(1) <<< (EST_W - 1 - F)) - longint'(1));
    localparam logic signed [EST_W-1:0] DC_LIM_LO =
        EST_W'(-(longint'(1) <<< (EST_W - 1 - F)));
    localparam logic signed [DIFF_W-1:0] HALF_LSB  = DIFF_W'(longint'(1) <<< (F - 1));
    localparam logic signed [DIFF_W-1:0] TRUNC_ADJ =
        DIFF_W'((longint'(1) <<< F) - longint'(1));
    localparam logic signed [DIFF_W-1:0] R_MAX = DIFF_W'(32767);
    localparam logic signed [DIFF_W-1:0] R_MIN = DIFF_W'(-32768);
    localparam logic signed [tpcc_pkg::SUM_W-1:0] O_MAX = tpcc_pkg::SUM_W'(32767);
    localparam logic signed [tpcc_pkg::SUM_W-1:0] O_MIN = tpcc_pkg::SUM_W'(-32768);
    localparam logic signed [tpcc_pkg::SUM_W-1:0] O_HALF =
        tpcc_pkg::SUM_W'(longint'(1) <<< (tpcc_pkg::LP_FRAC - 1));

    logic [3:0] state_reg, state_next;

    // State kept across items
    logic signed [EST_W-1:0] est_reg;
    logic signed [OUT_W-1:0] last_reg;

    // Per-item working registers
    logic [tpcc_pkg::RAW_W-1:0]               samp_reg;
    logic                                     stat_reg;
    logic signed [PROD_W-1:0]                 p_reg;
    logic signed [PROD_W-1:0]                 v_reg;
    logic signed [DIFF_W-1:0]                 d_reg;
    logic [tpcc_pkg::LO_P_W-1:0]              lo_reg;
    logic signed [tpcc_pkg::HI_P_W-1:0]       hi_reg;
    logic signed [EST_W-1:0]                  q_reg;
    logic signed [tpcc_pkg::C_W-1:0]          c_reg;
    logic signed [tpcc_pkg::M1_W-1:0]         m1_reg;
    logic signed [tpcc_pkg::M2_W-1:0]         m2_reg;

    logic signed [tpcc_pkg::NEG_W-1:0]        n_val;
    logic signed [PROD_W:0]                   p_full;
    logic signed [PROD_W-1:0]                 v_next;
    logic signed [EST_W-1:0]                  v_ext;
    logic signed [EST_W-1:0]                  v_clamp;
    logic signed [EST_W-1:0]                  s_val;
    logic signed [DIFF_W-1:0]                 d_next;
    logic [tpcc_pkg::LO_P_W-1:0]              lo_next;
    logic signed [tpcc_pkg::HI_P_W-1:0]       hi_next;
    logic signed [tpcc_pkg::UP_W-1:0]         up_val;
    logic signed [tpcc_pkg::UP_W-1:0]         up_shift;
    logic signed [DIFF_W-1:0]                 t_val;
    logic signed [DIFF_W-1:0]                 t_adj;
    logic signed [DIFF_W-1:0]                 r_full;
    logic signed [OUT_W-1:0]                  r_sat;
    logic signed [tpcc_pkg::C_W-1:0]          c_next;
    logic signed [tpcc_pkg::M1_W-1:0]         m1_next;
    logic signed [tpcc_pkg::M2_W-1:0]         m2_next;
    logic signed [tpcc_pkg::SUM_W-1:0]        sum_val;
    logic signed [tpcc_pkg::SUM_W-1:0]        o_full;
    logic signed [OUT_W-1:0]                  o_sat;

    // Negate around the offset, scale by the gain
    assign n_val  = $signed({2'b00, cfg.adc_offset}) - $signed({2'b00, samp_reg});
    assign p_full = n_val * $signed({1'b0, cfg.count_gain});
    assign v_next = p_reg >>> cfg.gain_shift;

    // Clamp into the estimate range and form the difference
    assign v_ext   = {{(EST_W - PROD_W){v_reg[PROD_W-1]}}, v_reg};
    assign v_clamp = (v_ext > DC_LIM_HI) ? DC_LIM_HI :
                     (v_ext < DC_LIM_LO) ? DC_LIM_LO : v_ext;
    assign s_val   = v_clamp <<< F;
    assign d_next  = $signed({s_val[EST_W-1], s_val}) - $signed({est_reg[EST_W-1], est_reg});

    // alpha * d in two partial products: unsigned low slice, signed high slice
    assign lo_next = cfg.dc_alpha * d_reg[tpcc_pkg::LO_W-1:0];
    assign hi_next = $signed({1'b0, cfg.dc_alpha}) * $signed(d_reg[DIFF_W-1:tpcc_pkg::LO_W]);

    // floor(alpha * d / 2^31): low bits of the low slice never reach the quotient
    assign up_val   = tpcc_pkg::UP_W'(hi_reg)
                    + $signed(tpcc_pkg::UP_W'(lo_reg[tpcc_pkg::LO_P_W-1:tpcc_pkg::LO_W]));
    assign up_shift = up_val >>> tpcc_pkg::Q_SHIFT;

    // Round half up, truncate toward zero, clamp to 16 bits
    assign t_val  = $signed({est_reg[EST_W-1], est_reg}) + HALF_LSB;
    assign t_adj  = t_val[DIFF_W-1] ? (t_val + TRUNC_ADJ) : t_val;
    assign r_full = t_adj >>> F;
    assign r_sat  = (r_full > R_MAX) ? OUT_W'(R_MAX) :
                    (r_full < R_MIN) ? OUT_W'(R_MIN) : r_full[OUT_W-1:0];
    assign c_next = $signed({v_reg[PROD_W-1], v_reg})
                  - $signed({{(tpcc_pkg::C_W - OUT_W){r_sat[OUT_W-1]}}, r_sat});

    // Low-pass products, then rounded sum and saturation
    assign m1_next = $signed({1'b0, cfg.lp_alpha}) * c_reg;
    assign m2_next = $signed({1'b0, cfg.lp_one_minus}) * last_reg;
    assign sum_val = tpcc_pkg::SUM_W'(m1_reg) + tpcc_pkg::SUM_W'(m2_reg) + O_HALF;
    assign o_full  = sum_val >>> tpcc_pkg::LP_FRAC;
    assign o_sat   = (o_full > O_MAX) ? OUT_W'(O_MAX) :
                     (o_full < O_MIN) ? OUT_W'(O_MIN) : o_full[OUT_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_SHIFT;
            ST_SHIFT: state_next = stat_reg ? ST_DIFF : ST_RND;
            ST_DIFF:  state_next = ST_PLO;
            ST_PLO:   state_next = ST_PHI;
            ST_PHI:   state_next = ST_QUO;
            ST_QUO:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_RND;
            ST_RND:   state_next = ST_LPM;
            ST_LPM:   state_next = ST_LPS;
            ST_LPS:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            est_reg   <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ACC)
            begin
                est_reg <= est_reg + q_reg;
            end
            if (state_reg == ST_LPS)
            begin
                last_reg <= o_sat;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && ctrl.start)
        begin
            samp_reg <= sample & tpcc_pkg::SAMPLE_MASK;
            stat_reg <= ctrl.stationary;
        end
        if (state_reg == ST_MUL)
        begin
            p_reg <= p_full[PROD_W-1:0];
        end
        if (state_reg == ST_SHIFT)
        begin
            v_reg <= v_next;
        end
        if (state_reg == ST_DIFF)
        begin
            d_reg <= d_next;
        end
        if (state_reg == ST_PLO)
        begin
            lo_reg <= lo_next;
        end
        if (state_reg == ST_PHI)
        begin
            hi_reg <= hi_next;
        end
        if (state_reg == ST_QUO)
        begin
            q_reg <= up_shift[EST_W-1:0];
        end
        if (state_reg == ST_RND)
        begin
            c_reg <= c_next;
        end
        if (state_reg == ST_LPM)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign result    = last_reg;

endmodule

`default_nettype wire

@@ rtl/tpcc_merge.sv @@
`default_nettype none

// Joins the two lane results into one output transfer and holds it
// until the consumer takes it, so the lanes can start the next pair.
module tpcc_merge (
    input  wire                               clk,
    input  wire                               rst_n,
    input  tpcc_pkg::lane_stat_t              lane_a,
    input  tpcc_pkg::lane_stat_t              lane_b,
    input  wire signed [tpcc_pkg::OUT_W-1:0]  result_a,
    input  wire signed [tpcc_pkg::OUT_W-1:0]  result_b,
    input  wire                               out_ready,
    output logic                              take,
    output logic                              out_valid,
    output logic signed [tpcc_pkg::OUT_W-1:0] current_a,
    output logic signed [tpcc_pkg::OUT_W-1:0] current_b
);

    logic                              valid_reg, valid_next;
    logic signed [tpcc_pkg::OUT_W-1:0] cur_a_reg;
    logic signed [tpcc_pkg::OUT_W-1:0] cur_b_reg;

    // Both lanes finished and the output register is free or draining
    assign take       = lane_a.done & lane_b.done & (~valid_reg | out_ready);
    assign valid_next = take | (valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_a_reg <= result_a;
            cur_b_reg <= result_b;
        end
    end

    assign out_valid = valid_reg;
    assign current_a = cur_a_reg;
    assign current_b = cur_b_reg;

endmodule

`default_nettype wire

@@ rtl/two_phase_current_conditioner.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    sample_a, sample_b, stationary
// output    out        out_valid / out_ready  current_a, current_b
// config    in         cfg_write              cfg_index, cfg_data (write only)
//
// Both phases run in separate lanes in lockstep; each lane steps its datapath
// through a sequence of states and takes a new input only when idle. With
// stationary clear, the DC estimate update states are skipped.
// Result is loaded once both lanes are done and the output register is free or draining;
// a stalled output holds one result while the lanes work on the next pair.
// Reset clears the DC estimates, the low-pass state and the handshakes,
// and loads the default configuration.
module two_phase_current_conditioner (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire [tpcc_pkg::RAW_W-1:0]            sample_a,
    input  wire [tpcc_pkg::RAW_W-1:0]            sample_b,
    input  wire                                  stationary,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic signed [tpcc_pkg::OUT_W-1:0]    current_a,
    output logic signed [tpcc_pkg::OUT_W-1:0]    current_b,
    input  wire                                  cfg_write,
    input  wire [tpcc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [tpcc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    tpcc_pkg::cfg_t       cfg_reg, cfg_next;
    tpcc_pkg::lane_ctrl_t lane_ctrl;
    tpcc_pkg::lane_stat_t stat_a, stat_b;
    logic signed [tpcc_pkg::OUT_W-1:0] res_a, res_b;
    logic                 take;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                tpcc_pkg::REG_ADC_OFFSET:
                    cfg_next.adc_offset = cfg_data[tpcc_pkg::RAW_W-1:0];
                tpcc_pkg::REG_COUNT_GAIN:
                    cfg_next.count_gain = cfg_data[tpcc_pkg::GAIN_W-1:0];
                tpcc_pkg::REG_GAIN_SHIFT:
                    cfg_next.gain_shift = cfg_data[tpcc_pkg::SHIFT_W-1:0];
                tpcc_pkg::REG_DC_ALPHA:
                    cfg_next.dc_alpha = cfg_data[tpcc_pkg::ALPHA_W-1:0];
                tpcc_pkg::REG_LP_ALPHA:
                    cfg_next.lp_alpha = cfg_data[tpcc_pkg::LP_W-1:0];
                tpcc_pkg::REG_LP_ONE_MINUS:
                    cfg_next.lp_one_minus = cfg_data[tpcc_pkg::LP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_offset   <= tpcc_pkg::RST_ADC_OFFSET;
            cfg_reg.count_gain   <= tpcc_pkg::RST_COUNT_GAIN;
            cfg_reg.gain_shift   <= tpcc_pkg::RST_GAIN_SHIFT;
            cfg_reg.dc_alpha     <= tpcc_pkg::RST_DC_ALPHA;
            cfg_reg.lp_alpha     <= tpcc_pkg::RST_LP_ALPHA;
            cfg_reg.lp_one_minus <= tpcc_pkg::RST_LP_ONE_MINUS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input transfer starts both lanes together
    assign in_ready             = stat_a.idle & stat_b.idle;
    assign lane_ctrl.start      = in_valid & in_ready;
    assign lane_ctrl.stationary = stationary;
    assign lane_ctrl.take       = take;

    tpcc_lane u_lane_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .ctrl   (lane_ctrl),
        .sample (sample_a),
        .stat   (stat_a),
        .result (res_a)
    );

    tpcc_lane u_lane_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .ctrl   (lane_ctrl),
        .sample (sample_b),
        .stat   (stat_b),
        .result (res_b)
    );

    tpcc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_a    (stat_a),
        .lane_b    (stat_b),
        .result_a  (res_a),
        .result_b  (res_b),
        .out_ready (out_ready),
        .take      (take),
        .out_valid (out_valid),
        .current_a (current_a),
        .current_b (current_b)
    );

endmodule

`default_nettype wire
